// ===== sv/pgca_pkg.sv =====
package pgca_pkg;

    // table sizes
    localparam int NUM_CPUS   = 1024;
    localparam int NUM_GROUPS = 4096;

    localparam int CPU_AW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int GID_AW    = $clog2(NUM_GROUPS);
    localparam int CLR_DEPTH = (NUM_CPUS > NUM_GROUPS) ? NUM_CPUS : NUM_GROUPS;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    // field widths
    localparam int CNT_W    = 64;
    localparam int CPU_W    = 10;
    localparam int GIN_W    = 16;
    localparam int LEVEL_W  = 8;
    localparam int GOUT_W   = 12;
    localparam int PREV_W   = 3 * CNT_W;
    localparam int GRP_W    = 4 * CNT_W;

    // slave tdata layout, lowest field first
    localparam int S_CPU_LO    = 0;
    localparam int S_GID_LO    = S_CPU_LO + CPU_W;
    localparam int S_SERIAL_LO = S_GID_LO + GIN_W;
    localparam int S_LEVEL_LO  = S_SERIAL_LO + CNT_W;
    localparam int S_ACT_LO    = S_LEVEL_LO + LEVEL_W;
    localparam int S_REF_LO    = S_ACT_LO + CNT_W;
    localparam int S_STAMP_LO  = S_REF_LO + CNT_W;
    localparam int S_USED_W    = S_STAMP_LO + CNT_W;
    localparam int S_DATA_W    = ((S_USED_W + 7) / 8) * 8;

    // master tdata layout
    localparam int M_USED_W = GOUT_W + LEVEL_W + 3 * CNT_W;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - M_USED_W;

    typedef struct packed {
        logic              load;     // word accepted, table reads issued
        logic              calc;     // read data valid, form deltas
        logic              wb;       // write back tables, load result
        logic              clear;    // clearing pass write
        logic [CLR_AW-1:0] clr_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;              // result register full and not taken
    } dp_sts_t;

endpackage

// ===== sv/pgca_ram.sv =====
module pgca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pgca_ctrl.sv =====
module pgca_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pgca_pkg::dp_sts_t sts,
    output pgca_pkg::dp_cmd_t cmd
);
    import pgca_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CALC  = 2'd2;
    localparam logic [1:0] S_WB    = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CLR_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_last;

    assign clr_last = (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1));
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        cmd          = '0;
        cmd.clr_addr = clr_cnt_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear    = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                // hold until the result register can take the word
                if (!sts.out_busy) begin
                    cmd.wb     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

endmodule

// ===== sv/pgca_dpath.sv =====
module pgca_dpath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [pgca_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pgca_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [1:0]                      m_tuser,
    input  pgca_pkg::dp_cmd_t               cmd,
    output pgca_pkg::dp_sts_t               sts
);
    import pgca_pkg::*;

    // input decode
    logic [CPU_W-1:0]   in_cpu;
    logic [GIN_W-1:0]   in_gid;
    logic [31:0]        in_cpu_ext, in_gid_ext, clr_ext;
    logic               in_cpu_ok, in_grp_ok;

    assign in_cpu     = s_tdata[S_CPU_LO +: CPU_W];
    assign in_gid     = s_tdata[S_GID_LO +: GIN_W];
    assign in_cpu_ext = 32'(in_cpu);
    assign in_gid_ext = 32'(in_gid);
    assign clr_ext    = 32'(cmd.clr_addr);
    assign in_cpu_ok  = (in_cpu_ext < NUM_CPUS);
    assign in_grp_ok  = s_tuser[0] && (in_gid != '0) && (in_gid_ext < NUM_GROUPS);

    // captured word
    logic              cpu_ok_reg, grp_ok_reg;
    logic [CPU_AW-1:0] cpu_addr_reg;
    logic [GID_AW-1:0] gid_addr_reg;
    logic [GOUT_W-1:0] gid_lo_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [CNT_W-1:0]  serial_reg, act_reg, ref_reg, stamp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cpu_ok_reg   <= in_cpu_ok;
            grp_ok_reg   <= in_grp_ok;
            cpu_addr_reg <= in_cpu_ext[CPU_AW-1:0];
            gid_addr_reg <= in_gid_ext[GID_AW-1:0];
            gid_lo_reg   <= in_gid[GOUT_W-1:0];
            level_reg    <= s_tdata[S_LEVEL_LO +: LEVEL_W];
            serial_reg   <= s_tdata[S_SERIAL_LO +: CNT_W];
            act_reg      <= s_tdata[S_ACT_LO +: CNT_W];
            ref_reg      <= s_tdata[S_REF_LO +: CNT_W];
            stamp_reg    <= s_tdata[S_STAMP_LO +: CNT_W];
        end
    end

    // tables: prev = {stamp, ref, act}; group = {serial, stamp, ref, act}
    logic              prev_we, grp_we;
    logic [CPU_AW-1:0] prev_waddr;
    logic [GID_AW-1:0] grp_waddr;
    logic [PREV_W-1:0] prev_wdata, prev_rdata;
    logic [GRP_W-1:0]  grp_wdata, grp_rdata;
    logic [CNT_W-1:0]  tot_act, tot_ref, tot_stamp;

    always_comb begin
        if (cmd.clear) begin
            prev_we    = (clr_ext < NUM_CPUS);
            prev_waddr = clr_ext[CPU_AW-1:0];
            prev_wdata = '0;
            grp_we     = (clr_ext < NUM_GROUPS);
            grp_waddr  = clr_ext[GID_AW-1:0];
            grp_wdata  = '0;
        end else begin
            prev_we    = cmd.wb && cpu_ok_reg;
            prev_waddr = cpu_addr_reg;
            prev_wdata = {stamp_reg, ref_reg, act_reg};
            grp_we     = cmd.wb && grp_ok_reg;
            grp_waddr  = gid_addr_reg;
            grp_wdata  = {serial_reg, tot_stamp, tot_ref, tot_act};
        end
    end

    pgca_ram #(.WIDTH(PREV_W), .DEPTH(NUM_CPUS)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (cmd.load),
        .raddr (in_cpu_ext[CPU_AW-1:0]),
        .rdata (prev_rdata)
    );

    pgca_ram #(.WIDTH(GRP_W), .DEPTH(NUM_GROUPS)) u_grp_ram (
        .aclk  (aclk),
        .we    (grp_we),
        .waddr (grp_waddr),
        .wdata (grp_wdata),
        .re    (cmd.load),
        .raddr (in_gid_ext[GID_AW-1:0]),
        .rdata (grp_rdata)
    );

    // deltas and base accumulators
    logic             fresh, fresh_reg;
    logic [CNT_W-1:0] d_act_reg, d_ref_reg, d_stamp_reg;
    logic [CNT_W-1:0] b_act_reg, b_ref_reg, b_stamp_reg;

    assign fresh = (grp_rdata[3*CNT_W +: CNT_W] != serial_reg);

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            fresh_reg   <= fresh;
            d_act_reg   <= cpu_ok_reg ? act_reg   - prev_rdata[0 +: CNT_W]       : '0;
            d_ref_reg   <= cpu_ok_reg ? ref_reg   - prev_rdata[CNT_W +: CNT_W]   : '0;
            d_stamp_reg <= cpu_ok_reg ? stamp_reg - prev_rdata[2*CNT_W +: CNT_W] : '0;
            b_act_reg   <= fresh ? '0 : grp_rdata[0 +: CNT_W];
            b_ref_reg   <= fresh ? '0 : grp_rdata[CNT_W +: CNT_W];
            b_stamp_reg <= fresh ? '0 : grp_rdata[2*CNT_W +: CNT_W];
        end
    end

    assign tot_act   = b_act_reg + d_act_reg;
    assign tot_ref   = b_ref_reg + d_ref_reg;
    assign tot_stamp = b_stamp_reg + d_stamp_reg;

    // result register
    logic               out_valid_reg, out_acc_reg, out_new_reg;
    logic [GOUT_W-1:0]  out_gid_reg;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [CNT_W-1:0]   out_act_reg, out_ref_reg, out_stamp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.wb) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            out_acc_reg   <= grp_ok_reg;
            out_new_reg   <= grp_ok_reg && fresh_reg;
            out_gid_reg   <= grp_ok_reg ? gid_lo_reg : '0;
            out_level_reg <= (grp_ok_reg && fresh_reg) ? level_reg : '0;
            out_act_reg   <= grp_ok_reg ? tot_act   : '0;
            out_ref_reg   <= grp_ok_reg ? tot_ref   : '0;
            out_stamp_reg <= grp_ok_reg ? tot_stamp : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_new_reg, out_acc_reg};
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_stamp_reg, out_ref_reg, out_act_reg,
                       out_level_reg, out_gid_reg};
    assign sts.out_busy = out_valid_reg && !m_tready;

endmodule

// ===== sv/per_group_cycle_counter_attribution.sv =====
// Per-group cycle counter attribution.
// Slave channel: one word per context-switch event (processor, outgoing
// group id, serial, level and three raw counter readings). Master channel:
// exactly one word per event with the group's updated totals.
// Each processor's last readings and each group's serial and three
// accumulators sit in two single-port-read RAMs (processor table and group
// table). An event goes through table read, delta/serial check, then
// add and write-back. s_tready is high only in idle, so a new event is
// taken only after the last is written back (the group table's
// read-modify-write sets this). m_tvalid is registered, set at write-back.
// Reset: aresetn low clears control state; after release the block sweeps
// both tables to zero, one entry a cycle, with s_tready low throughout.
// Stall: the result waits in an output register; a new event is still
// taken and worked on, and waits at write-back only if the previous word
// has not been taken by then.
// Rejected events (no group, id zero or id beyond the table) give a word
// with all fields zero; the processor's readings are still updated.
module per_group_cycle_counter_attribution (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave side
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cpu[9:0], group_id[25:10], serial[89:26], level[97:90],
    // active_count[161:98], ref_count[225:162], stamp_count[289:226], zero fill
    input  logic [pgca_pkg::S_DATA_W-1:0] s_tdata,
    // has_group[0]
    input  logic [0:0]                    s_tuser,
    // master side
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_group_id[11:0], out_level[19:12], active_total[83:20],
    // ref_total[147:84], stamp_total[211:148], zero fill
    output logic [pgca_pkg::M_DATA_W-1:0] m_tdata,
    // accepted[0], new_group[1]
    output logic [1:0]                    m_tuser
);
    import pgca_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    pgca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pgca_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== sv/pgca_checker.sv =====
module pgca_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pgca_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);
    import pgca_pkg::*;

    // held result word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // table sweep keeps the slave side closed straight after reset
    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("word taken during table clear");

    // one event in flight
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // new group only on an attributed event
    a_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("new group without acceptance");

    // rejected events carry an all-zero word
    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tuser == 2'b00) && (m_tdata == '0))
        else $error("rejected event with nonzero payload");

endmodule

bind per_group_cycle_counter_attribution pgca_checker u_pgca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
